// ===== src/gnm_pkg.sv =====
package gnm_pkg;

  // Pattern storage fixed by the configuration registers
  localparam int unsigned PAT_STORE = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned PAT_LEN_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_ANY   = 8'h3F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  // Per-position pattern info, derived from the configuration registers
  typedef struct packed {
    logic [7:0] fold_char;
    logic       star;
    logic       any;
    logic       used;
  } pat_cell_t;

  // Broadcast to every cell for the current transaction
  typedef struct packed {
    logic [7:0] ch_fold;
    logic       accept;
    logic       do_step;
    logic       save;
    logic       rearm;
  } step_ctl_t;

  // Handed from one cell to the next
  typedef struct packed {
    logic step;
    logic close;
    logic init;
  } link_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      r = c + CASE_GAP;
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

endpackage

// ===== src/gnm_cell.sv =====
module gnm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gnm_pkg::pat_cell_t  info_i,
  input  gnm_pkg::step_ctl_t  ctl_i,
  input  gnm_pkg::link_t      link_i,
  output gnm_pkg::link_t      link_o,
  output logic                saved_next_o
);

  logic act_q, act_d;
  logic sav_q, sav_d;
  logic act_cur, sav_cur;
  logic reach;
  logic hit;

  // After a re-arm the position holds the start closure, not the stored bit
  assign act_cur = ctl_i.rearm ? link_i.init : act_q;
  assign sav_cur = ctl_i.rearm ? link_i.init : sav_q;

  assign hit = info_i.any || (info_i.fold_char == ctl_i.ch_fold);

  // Reached by a step from the left, by star closure, or by staying on a star
  assign reach = link_i.step | link_i.close | (act_cur & info_i.used & info_i.star);

  assign link_o.step  = act_cur & info_i.used & ~info_i.star & hit;
  assign link_o.close = reach & info_i.used & info_i.star;
  assign link_o.init  = link_i.init & info_i.used & info_i.star;

  assign act_d = ctl_i.do_step ? reach : act_cur;
  assign sav_d = ctl_i.save ? reach : sav_cur;

  assign saved_next_o = sav_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      sav_q <= 1'b0;
    end else if (ctl_i.accept) begin
      act_q <= act_d;
      sav_q <= sav_d;
    end
  end

endmodule

// ===== src/gnm_pattern.sv =====
module gnm_pattern #(
  parameter int unsigned CELLS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gnm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [gnm_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output gnm_pkg::pat_cell_t [CELLS-1:0]       info_o,
  output logic [CELLS:0]                       end_sel_o,
  output logic                                 rearm_req_o,
  output logic                                 busy_o
);

  logic [gnm_pkg::CFG_DATA_W-1:0]  pat_low_q;
  logic [gnm_pkg::CFG_DATA_W-1:0]  pat_high_q;
  logic [gnm_pkg::PAT_LEN_W-1:0]   pat_len_q;
  logic [2*gnm_pkg::CFG_DATA_W-1:0] pat_all;
  logic                             hit_reg;
  logic                             pend_q;

  logic [CELLS-1:0] in_prefix;
  logic [CELLS-1:0] keep;
  logic [CELLS-1:0] used;
  logic [CELLS:0]   end_sel_d;
  gnm_pkg::pat_cell_t [CELLS-1:0] info_d;
  gnm_pkg::pat_cell_t [CELLS-1:0] info_q;
  logic [CELLS:0]   end_sel_q;

  assign pat_all = {pat_high_q, pat_low_q};

  assign hit_reg = cfg_we_i && (cfg_index_i == gnm_pkg::CFG_PAT_LOW ||
                                cfg_index_i == gnm_pkg::CFG_PAT_HIGH ||
                                cfg_index_i == gnm_pkg::CFG_PAT_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
      pend_q     <= 1'b0;
    end else begin
      pend_q <= hit_reg;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          gnm_pkg::CFG_PAT_LOW:  pat_low_q  <= cfg_data_i;
          gnm_pkg::CFG_PAT_HIGH: pat_high_q <= cfg_data_i;
          gnm_pkg::CFG_PAT_LEN:  pat_len_q  <= cfg_data_i[gnm_pkg::PAT_LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Positions before the length limit and before the first NUL
  always_comb begin
    logic run;
    run = 1'b1;
    for (int i = 0; i < CELLS; i++) begin
      run = run && (pat_all[8*i +: 8] != gnm_pkg::CHAR_NUL) &&
            (gnm_pkg::PAT_LEN_W'(i) < pat_len_q);
      in_prefix[i] = run;
      keep[i] = run && !gnm_pkg::is_blank(pat_all[8*i +: 8]);
    end
  end

  // A position is in use if some kept character lies at or after it (trailing trim)
  always_comb begin
    logic any_keep;
    any_keep = 1'b0;
    for (int i = CELLS - 1; i >= 0; i--) begin
      any_keep = any_keep || keep[i];
      used[i] = any_keep;
    end
  end

  always_comb begin
    end_sel_d[0] = 1'b0;
    for (int j = 1; j < CELLS; j++) begin
      end_sel_d[j] = used[j-1] && !used[j];
    end
    end_sel_d[CELLS] = used[CELLS-1];
  end

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      info_d[i].fold_char = gnm_pkg::fold_case(pat_all[8*i +: 8]);
      info_d[i].star      = (pat_all[8*i +: 8] == gnm_pkg::CHAR_STAR);
      info_d[i].any       = (pat_all[8*i +: 8] == gnm_pkg::CHAR_ANY);
      info_d[i].used      = used[i] && in_prefix[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      info_q    <= '0;
      end_sel_q <= '0;
    end else begin
      info_q    <= info_d;
      end_sel_q <= end_sel_d;
    end
  end

  assign info_o      = info_q;
  assign end_sel_o   = end_sel_q;
  assign rearm_req_o = hit_reg;
  assign busy_o      = pend_q;

endmodule

// ===== src/gnm_out_buf.sv =====
module gnm_out_buf (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic push_matched_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic out_matched_o
);

  logic main_valid_q, main_data_q;
  logic skid_valid_q, skid_data_q;
  logic pop;

  assign pop = main_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (pop && skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= push_i;
      end else if (pop || !main_valid_q) begin
        main_valid_q <= push_i;
      end else if (push_i) begin
        // hold the stalled transaction, park the new one
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (pop && skid_valid_q) begin
      main_data_q <= skid_data_q;
      skid_data_q <= push_matched_i;
    end else if (pop || !main_valid_q) begin
      main_data_q <= push_matched_i;
    end else if (push_i) begin
      skid_data_q <= push_matched_i;
    end
  end

  assign full_o        = skid_valid_q;
  assign out_valid_o   = main_valid_q;
  assign out_matched_o = main_data_q;

endmodule

// ===== src/glob_name_matcher.sv =====
// Glob name matcher. Name bytes stream in one per transaction on in_ch_i, with
// in_last_i marking the final byte; that transaction yields one result whose
// out_matched_o tells whether the name matches the pattern written through the
// configuration port ('*' any run, '?' any one byte, A-Z folded to a-z, trailing
// spaces and tabs ignored on both sides, a NUL ends the name, bytes past NAME_MAX
// ignored, an empty pattern never matches). One byte is taken every cycle while
// in_stall_o is low: a row of one cell per pattern position updates its active
// bit as each byte is taken, the star closure rippling along the row. The result
// is pushed into a two-entry output buffer when the last byte is taken, which keeps
// input flowing while the result waits. After a write to a pattern register (low,
// high or length) the input stalls while the per-position pattern info is rebuilt;
// such a write also restarts the current name.
module glob_name_matcher #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned NAME_MAX    = 63
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gnm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gnm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       in_ch_i,
  input  logic                             in_last_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             out_matched_o
);

  localparam int unsigned CELLS =
      (PATTERN_MAX < gnm_pkg::PAT_STORE) ? PATTERN_MAX : gnm_pkg::PAT_STORE;
  localparam int unsigned CNT_W = $clog2(NAME_MAX + 1);

  gnm_pkg::pat_cell_t [CELLS-1:0] info;
  logic [CELLS:0]                 end_sel;
  logic                           rearm_req;
  logic                           cfg_busy;
  logic                           buf_full;

  gnm_pkg::step_ctl_t ctl;
  gnm_pkg::link_t     links [CELLS+2];
  logic [CELLS:0]     saved_next;

  logic             rearm_q;
  logic             ended_q, ended_d, ended_cur;
  logic [CNT_W-1:0] count_q, count_d, count_cur;
  logic             accept;
  logic             matched;

  gnm_pattern #(
    .CELLS (CELLS)
  ) u_pattern (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .info_o      (info),
    .end_sel_o   (end_sel),
    .rearm_req_o (rearm_req),
    .busy_o      (cfg_busy)
  );

  assign in_stall_o = buf_full | cfg_busy;
  assign accept     = in_valid_i & ~in_stall_o;

  assign ended_cur = ~rearm_q & ended_q;
  assign count_cur = rearm_q ? '0 : count_q;

  assign ctl.accept  = accept;
  assign ctl.rearm   = rearm_q;
  assign ctl.ch_fold = gnm_pkg::fold_case(in_ch_i);
  assign ctl.do_step = accept && !ended_cur && (in_ch_i != gnm_pkg::CHAR_NUL) &&
                       (count_cur < CNT_W'(NAME_MAX));
  assign ctl.save    = ctl.do_step && !gnm_pkg::is_blank(in_ch_i);

  assign ended_d = ended_cur | (in_ch_i == gnm_pkg::CHAR_NUL);
  assign count_d = count_cur + CNT_W'(ctl.do_step);

  // Position 0 is always in the start set
  assign links[0].step  = 1'b0;
  assign links[0].close = 1'b0;
  assign links[0].init  = 1'b1;

  for (genvar i = 0; i <= CELLS; i++) begin : g_cell
    gnm_pkg::pat_cell_t cell_info;
    if (i < CELLS) begin : g_pat
      assign cell_info = info[i];
    end else begin : g_tail
      // final position has no pattern character
      assign cell_info = '0;
    end
    gnm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .info_i       (cell_info),
      .ctl_i        (ctl),
      .link_i       (links[i]),
      .link_o       (links[i+1]),
      .saved_next_o (saved_next[i])
    );
  end

  assign matched = |(saved_next & end_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rearm_q <= 1'b1;
      ended_q <= 1'b0;
      count_q <= '0;
    end else begin
      if (accept) begin
        ended_q <= ended_d;
        count_q <= count_d;
      end
      if (rearm_req || (accept && in_last_i)) begin
        rearm_q <= 1'b1;
      end else if (accept) begin
        rearm_q <= 1'b0;
      end
    end
  end

  gnm_out_buf u_out_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (accept & in_last_i),
    .push_matched_i (matched),
    .full_o         (buf_full),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_matched_o  (out_matched_o)
  );

endmodule
